### sv/amsdu_pkg.sv
`default_nettype none

package amsdu_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned TDATA_W = 136;
  localparam int unsigned TUSER_W = 2;

  localparam logic [3:0] HDR_LAST_BYTE = 4'd13;
  localparam logic [3:0] DEST_END      = 4'd6;
  localparam logic [3:0] SRC_END       = 4'd12;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_PAD     = 2'd2;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_CUT     = 2'd2;

  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        payload_byte;
    logic              msdu_last;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [LEN_W-1:0]  msdu_length;
    logic [IDX_W-1:0]  msdu_index;
    logic              truncated;
  } result_t;

  // pad bytes that bring a 14-byte header plus payload to a 4-byte boundary
  function automatic logic [1:0] pad_for(input logic [LEN_W-1:0] len);
    logic [1:0] rem;
    rem = len[1:0] + 2'd2;
    return 2'd0 - rem;
  endfunction

endpackage

`default_nettype wire

### sv/amsdu_deaggregator_core.sv
// A-MSDU deaggregator core.
// Input stream (s_axis_*): one byte of the aggregated frame per item, tlast on
// the final byte of the frame. Output stream (m_axis_*): one item per payload
// byte, one marker item per empty subframe and one item when the frame is cut
// inside a header. tuser carries the item kind, tlast marks the final payload
// byte (or the empty marker) of a subframe, tdata carries the byte together
// with the subframe header, the subframe index and a truncation flag.
// A result is registered in out_reg and presented in the cycle after its input byte is accepted.
// Throughput: one byte per clock while the receiver does not stall, with the
// output register as the single register stage after the input handshake.
// Pad bytes produce no output item; header bytes produce one only as an empty marker or a cut.
// Reset clears the parser to the start of a header with index 0 and empties
// the output register. When the receiver stalls, the held result stays on
// m_axis_tdata and s_axis_tready drops until it is taken; input is accepted in
// the same cycle that the output item is taken.
`default_nettype none

module amsdu_deaggregator_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [7:0]                       s_axis_tdata,  // data_byte
  input  wire logic                             s_axis_tlast,  // frame_last
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // payload_byte[7:0], dest_addr[55:8], src_addr[103:56], msdu_length[119:104],
  // msdu_index[127:120], truncated[128], zero fill [135:129]
  output logic [amsdu_pkg::TDATA_W-1:0]         m_axis_tdata,
  output logic                                  m_axis_tlast,  // msdu_last
  output logic [amsdu_pkg::TUSER_W-1:0]         m_axis_tuser   // kind
);

  import amsdu_pkg::*;

  logic [1:0]        phase;
  logic [3:0]        header_count;
  logic [ADDR_W-1:0] dest_reg;
  logic [ADDR_W-1:0] src_reg;
  logic [LEN_W-1:0]  length_reg;
  logic [LEN_W-1:0]  bytes_left;
  logic [1:0]        pad_left;
  logic [IDX_W-1:0]  index_reg;
  result_t           out_reg;

  logic [1:0]        phase_next;
  logic [3:0]        header_count_next;
  logic [ADDR_W-1:0] dest_next;
  logic [ADDR_W-1:0] src_next;
  logic [LEN_W-1:0]  length_next;
  logic [LEN_W-1:0]  bytes_left_next;
  logic [1:0]        pad_left_next;
  logic [IDX_W-1:0]  index_next;
  logic              emit;
  result_t           res;

  logic in_accept;
  logic [7:0] b;
  logic fl;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign fl            = s_axis_tlast;

  always_comb begin
    logic [ADDR_W-1:0] dest_base;
    logic [ADDR_W-1:0] src_base;
    logic [LEN_W-1:0]  len_base;
    logic              last_byte;
    logic              end_sub;
    phase_next        = phase;
    header_count_next = header_count;
    dest_next         = dest_reg;
    src_next          = src_reg;
    length_next       = length_reg;
    bytes_left_next   = bytes_left;
    pad_left_next     = pad_left;
    index_next        = index_reg;
    emit              = 1'b0;
    end_sub           = 1'b0;
    last_byte         = (bytes_left <= LEN_W'(1));
    dest_base         = (header_count == 4'd0) ? '0 : dest_reg;
    src_base          = (header_count == 4'd0) ? '0 : src_reg;
    len_base          = (header_count == 4'd0) ? '0 : length_reg;

    res.kind         = KIND_PAYLOAD;
    res.payload_byte = 8'd0;
    res.msdu_last    = 1'b0;
    res.dest_addr    = dest_reg;
    res.src_addr     = src_reg;
    res.msdu_length  = length_reg;
    res.msdu_index   = index_reg;
    res.truncated    = 1'b0;

    case (phase)
      PH_PAYLOAD: begin
        emit             = 1'b1;
        res.payload_byte = b;
        res.msdu_last    = last_byte || fl;
        res.truncated    = fl && !last_byte;
        if (bytes_left != '0) begin
          bytes_left_next = bytes_left - LEN_W'(1);
        end
        end_sub = last_byte;
      end
      PH_PAD: begin
        if (pad_left != 2'd0) begin
          pad_left_next = pad_left - 2'd1;
        end
        if (pad_left <= 2'd1) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
        dest_next   = dest_base;
        src_next    = src_base;
        length_next = len_base;
        if (header_count < DEST_END) begin
          dest_next = {dest_base[ADDR_W-9:0], b};
        end else if (header_count < SRC_END) begin
          src_next = {src_base[ADDR_W-9:0], b};
        end else begin
          length_next = {len_base[LEN_W-9:0], b};
        end
        res.dest_addr   = dest_next;
        res.src_addr    = src_next;
        res.msdu_length = length_next;
        if (header_count >= HDR_LAST_BYTE) begin
          if (length_next == '0) begin
            emit          = 1'b1;
            res.kind      = KIND_EMPTY;
            res.msdu_last = 1'b1;
            end_sub       = 1'b1;
          end else if (fl) begin
            emit          = 1'b1;
            res.kind      = KIND_CUT;
            res.truncated = 1'b1;
          end else begin
            bytes_left_next   = length_next;
            phase_next        = PH_PAYLOAD;
            header_count_next = 4'd0;
          end
        end else begin
          header_count_next = header_count + 4'd1;
          phase_next        = PH_HEADER;
          if (fl) begin
            emit          = 1'b1;
            res.kind      = KIND_CUT;
            res.truncated = 1'b1;
          end
        end
      end
    endcase

    if (end_sub) begin
      if (index_reg != IDX_MAX) begin
        index_next = index_reg + IDX_W'(1);
      end
      pad_left_next     = pad_for(length_next);
      phase_next        = (pad_left_next != 2'd0) ? PH_PAD : PH_HEADER;
      header_count_next = 4'd0;
    end

    if (fl) begin
      phase_next        = PH_HEADER;
      header_count_next = 4'd0;
      bytes_left_next   = '0;
      pad_left_next     = 2'd0;
      index_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= 4'd0;
      dest_reg     <= '0;
      src_reg      <= '0;
      length_reg   <= '0;
      bytes_left   <= '0;
      pad_left     <= 2'd0;
      index_reg    <= '0;
    end else if (in_accept) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      dest_reg     <= dest_next;
      src_reg      <= src_next;
      length_reg   <= length_next;
      bytes_left   <= bytes_left_next;
      pad_left     <= pad_left_next;
      index_reg    <= index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_reg <= res;
    end
  end

  assign m_axis_tuser = out_reg.kind;
  assign m_axis_tlast = out_reg.msdu_last;
  assign m_axis_tdata = {7'd0, out_reg.truncated, out_reg.msdu_index, out_reg.msdu_length,
                         out_reg.src_addr, out_reg.dest_addr, out_reg.payload_byte};

endmodule

`default_nettype wire

### bench/testbench.sv
`default_nettype none

module testbench;
  import amsdu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_LEN    = 250;
  localparam int RANDOM_ITEMS = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = 8'h00;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tlast;
  logic [TUSER_W-1:0]   m_axis_tuser;

  wire_byte_t bytes_to_send[$];
  result_t    pending_results[$];
  int         err_count = 0;
  int         cycle_count = 0;

  // parser state as seen by the predictor
  logic [1:0]        pr_phase = PH_HEADER;
  logic [3:0]        hdr_cnt = '0;
  logic [ADDR_W-1:0] cur_dest = '0;
  logic [ADDR_W-1:0] cur_src = '0;
  logic [LEN_W-1:0]  cur_len = '0;
  logic [LEN_W-1:0]  pay_left = '0;
  logic [1:0]        pads_due = '0;
  logic [IDX_W-1:0]  sub_idx = '0;

  // sender and receiver pacing
  wire_byte_t next_item;
  int         gap_left = 0;
  int         burst_left = 0;
  int         hold_left = 0;
  int         rx_cycle = 0;
  int         rx_mode = 0;
  int         mode_left = 0;

  amsdu_deaggregator_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  task automatic queue_result(input logic [1:0] k, input logic [7:0] b, input logic ml,
                              input logic tr);
    result_t r;
    r.kind         = k;
    r.payload_byte = b;
    r.msdu_last    = ml;
    r.dest_addr    = cur_dest;
    r.src_addr     = cur_src;
    r.msdu_length  = cur_len;
    r.msdu_index   = sub_idx;
    r.truncated    = tr;
    pending_results = {pending_results, r};
  endtask

  task automatic close_subframe();
    int unsigned rem;
    rem = (int'(cur_len) + 14) % 4;
    if (sub_idx != IDX_MAX) sub_idx = sub_idx + 1'b1;
    pads_due = 2'((4 - rem) % 4);
    pr_phase = (pads_due != 0) ? PH_PAD : PH_HEADER;
    hdr_cnt  = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fl);
    logic       fin;
    logic [3:0] c;
    if (pr_phase == PH_PAYLOAD) begin
      fin = (pay_left <= 1);
      queue_result(KIND_PAYLOAD, b, fin | fl, fl & ~fin);
      if (pay_left != 0) pay_left = pay_left - 1'b1;
      if (fin) close_subframe();
    end else if (pr_phase == PH_PAD) begin
      if (pads_due != 0) pads_due = pads_due - 1'b1;
      if (pads_due == 0) pr_phase = PH_HEADER;
    end else begin
      c = hdr_cnt;
      if (c == 0) begin
        cur_dest = '0;
        cur_src  = '0;
        cur_len  = '0;
      end
      if (c < 6) cur_dest = {cur_dest[ADDR_W-9:0], b};
      else if (c < 12) cur_src = {cur_src[ADDR_W-9:0], b};
      else cur_len = {cur_len[7:0], b};
      if (c >= HDR_LAST_BYTE) begin
        if (cur_len == 0) begin
          queue_result(KIND_EMPTY, 8'h00, 1'b1, 1'b0);
          close_subframe();
        end else if (fl) begin
          queue_result(KIND_CUT, 8'h00, 1'b0, 1'b1);
        end else begin
          pay_left = cur_len;
          pr_phase = PH_PAYLOAD;
          hdr_cnt  = '0;
        end
      end else begin
        hdr_cnt  = c + 1'b1;
        pr_phase = PH_HEADER;
        if (fl) queue_result(KIND_CUT, 8'h00, 1'b0, 1'b1);
      end
    end
    if (fl) begin
      pr_phase = PH_HEADER;
      hdr_cnt  = '0;
      pay_left = '0;
      pads_due = '0;
      sub_idx  = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("unexpected item kind %0d tdata 0x%0h", m_axis_tuser,
                             m_axis_tdata));
    end else begin
      want = pending_results.pop_front();
      check_field("kind", 64'(m_axis_tuser), 64'(want.kind));
      check_field("payload_byte", 64'(m_axis_tdata[7:0]), 64'(want.payload_byte));
      check_field("msdu_last", 64'(m_axis_tlast), 64'(want.msdu_last));
      check_field("dest_addr", 64'(m_axis_tdata[55:8]), 64'(want.dest_addr));
      check_field("src_addr", 64'(m_axis_tdata[103:56]), 64'(want.src_addr));
      check_field("msdu_length", 64'(m_axis_tdata[119:104]), 64'(want.msdu_length));
      check_field("msdu_index", 64'(m_axis_tdata[127:120]), 64'(want.msdu_index));
      check_field("truncated", 64'(m_axis_tdata[128]), 64'(want.truncated));
      check_field("fill", 64'(m_axis_tdata[135:129]), 64'd0);
    end
  endtask

  // sender: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
      burst_left    <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0 || bytes_to_send.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        next_item = bytes_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_item.data;
        s_axis_tlast  <= next_item.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall modes that change over time, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_cycle      <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_cycle == HOLD_AT) begin
        hold_left     <= HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   <= $urandom_range(0, 2);
          mode_left <= $urandom_range(20, 200);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (rx_mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          default: begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // predict on accepted input, then check accepted output
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rand_addr();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic int pad_count(input int len);
    return (4 - (len + 14) % 4) % 4;
  endfunction

  // stop_at: index within the subframe of the final byte sent, -1 for all
  task automatic add_subframe(input logic [47:0] da, input logic [47:0] sa,
                              input logic [15:0] len, input int stop_at,
                              input bit ends_frame);
    int         total;
    int         n;
    wire_byte_t w;
    total = 14 + int'(len) + pad_count(int'(len));
    n = (stop_at >= 0 && stop_at < total) ? stop_at + 1 : total;
    for (int i = 0; i < n; i++) begin
      if (i < 6) w.data = da[47 - 8*i -: 8];
      else if (i < 12) w.data = sa[47 - 8*(i-6) -: 8];
      else if (i == 12) w.data = len[15:8];
      else if (i == 13) w.data = len[7:0];
      else w.data = 8'($urandom);
      w.last = ends_frame && (i == n - 1);
      bytes_to_send = {bytes_to_send, w};
    end
  endtask

  initial begin
    int          sent;
    int          nsub;
    int          style;
    int          stop;
    int          npad;
    logic [15:0] len;
    wire_byte_t  w;

    // extremes of addresses, end right after the payload
    add_subframe(48'hFFFF_FFFF_FFFF, 48'h0, 16'd1, 14, 1'b1);
    // pad skipping between subframes
    add_subframe(48'h0, 48'hFFFF_FFFF_FFFF, 16'd3, -1, 1'b0);
    add_subframe(rand_addr(), rand_addr(), 16'd2, -1, 1'b0);
    add_subframe(rand_addr(), rand_addr(), 16'd5, 18, 1'b1);
    // empty subframe with its pad, then payload
    add_subframe(rand_addr(), rand_addr(), 16'd0, -1, 1'b0);
    add_subframe(rand_addr(), rand_addr(), 16'd4, 17, 1'b1);
    // empty subframe closing the frame
    add_subframe(rand_addr(), rand_addr(), 16'd0, 13, 1'b1);
    // cuts inside the header
    add_subframe(48'hFFFF_FFFF_FFFF, rand_addr(), 16'd7, 0, 1'b1);
    add_subframe(rand_addr(), rand_addr(), 16'd7, 5, 1'b1);
    add_subframe(rand_addr(), 48'hFFFF_FFFF_FFFF, 16'hFFFF, 12, 1'b1);
    // cut right after a full header
    add_subframe(rand_addr(), rand_addr(), 16'hFFFF, 13, 1'b1);
    // cut inside a long payload
    add_subframe(rand_addr(), rand_addr(), 16'h8000, 16, 1'b1);
    // frame ends inside the pad, or on the last byte of an unpadded subframe
    add_subframe(rand_addr(), rand_addr(), 16'd1, 15, 1'b1);
    add_subframe(rand_addr(), rand_addr(), 16'd2, 13 + 2, 1'b1);
    add_subframe(rand_addr(), rand_addr(), 16'd2, 15, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      stop = bytes_to_send.size();
      if ($urandom_range(0, 9) == 0) begin
        // noise frame
        nsub = $urandom_range(1, 30);
        for (int i = 0; i < nsub; i++) begin
          w.data = 8'($urandom);
          w.last = (i == nsub - 1);
          bytes_to_send = {bytes_to_send, w};
        end
      end else begin
        nsub = $urandom_range(1, 5);
        for (int s = 0; s < nsub; s++) begin
          len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(13, 60))
                                            : 16'($urandom_range(0, 12));
          if (s < nsub - 1) begin
            add_subframe(rand_addr(), rand_addr(), len, -1, 1'b0);
          end else begin
            style = $urandom_range(0, 9);
            npad  = pad_count(int'(len));
            if (style < 6) begin
              add_subframe(rand_addr(), rand_addr(), len, 13 + int'(len), 1'b1);
            end else if (style < 7 && npad > 0) begin
              add_subframe(rand_addr(), rand_addr(), len,
                           14 + int'(len) + $urandom_range(0, npad - 1), 1'b1);
            end else begin
              if ($urandom_range(0, 1) == 1) len = 16'($urandom);
              add_subframe(rand_addr(), rand_addr(), len,
                           $urandom_range(0, 13 + (len < 8 ? int'(len) : 8)), 1'b1);
            end
          end
        end
      end
      sent += bytes_to_send.size() - stop;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (bytes_to_send.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d items never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
